// ===== rtl/vrp_pkg.sv =====
package vrp_pkg;

    // Default size of the video byte store.
    localparam int unsigned STORE_DEPTH_DEF = 16384;

    // Width of the video address; it wraps at this many bits.
    localparam int unsigned ADDR_W = 14;

    // Fixed value returned by a status read.
    localparam logic [7:0] STATUS_VALUE = 8'hC0;

    // Address increments after a data access.
    localparam logic [ADDR_W-1:0] STEP_WIDE   = 14'd32;
    localparam logic [ADDR_W-1:0] STEP_NARROW = 14'd1;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register select codes.
    localparam logic [2:0] SEL_CTRL1   = 3'd0;
    localparam logic [2:0] SEL_CTRL2   = 3'd1;
    localparam logic [2:0] SEL_STATUS  = 3'd2;
    localparam logic [2:0] SEL_ADDRESS = 3'd3;
    localparam logic [2:0] SEL_DATA    = 3'd4;

    // Access strobes from the register decode to the byte store.
    typedef struct packed {
        logic wr;
        logic rd;
    } store_ctl_t;

    // Reduces a 14-bit address modulo the store depth. The depth is at least
    // a sixteenth of the address range, so four conditional subtractions of
    // the depth times eight, four, two and one are enough.
    function automatic logic [ADDR_W-1:0] addr_mod(input logic [ADDR_W-1:0] addr,
                                                   input int unsigned depth);
        logic [19:0] rem;
        logic [19:0] sub;
        rem = {6'b0, addr};
        for (int k = 3; k >= 0; k--) begin
            sub = 20'(depth) << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/vrp_store.sv =====
module vrp_store #(
    parameter int unsigned STORE_DEPTH = vrp_pkg::STORE_DEPTH_DEF,
    parameter int unsigned IDX_W       = $clog2(STORE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  vrp_pkg::store_ctl_t ctl,
    input  logic [IDX_W-1:0]   index,
    input  logic [7:0]         wdata,
    output logic [7:0]         rdata,
    output logic               busy
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

    logic [7:0]       store_mem_reg [STORE_DEPTH];
    logic [7:0]       rdata_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    // Clearing pass after reset: one entry is zeroed per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_IDX) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Single-port byte store with a registered read.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            store_mem_reg[clr_cnt_reg] <= 8'h00;
        end else if (ctl.wr) begin
            store_mem_reg[index] <= wdata;
        end
        if (ctl.rd) begin
            rdata_reg <= store_mem_reg[index];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

// ===== rtl/video_ram_register_port_unit.sv =====
// Video RAM register port.
// Each item on the s_ channel is one bus access: a read or a write of the
// control 1, control 2, status, address or data register. Each accepted item
// gives exactly one item on the m_ channel carrying the byte read back (writes
// to control and address registers echo the byte, other writes give zero).
// From acceptance to m_tvalid an item passes the middle stage and the output
// register: the register decode and the store access happen at the accept
// edge, the store read data is registered, and the result then lands in the
// output register once the output is free. One item is accepted per cycle
// while the output is free and the store is not clearing; the single-port
// store serves the one access that each item makes. After reset the store is
// cleared one byte per cycle; s_tready stays low over that pass. The control,
// address and address-toggle registers and the dummy flag reset to zero.
// When the receiver stalls, the output item holds and one further item can
// sit in the middle stage; s_tready then drops until the output is taken.
module video_ram_register_port_unit #(
    parameter int unsigned STORE_DEPTH = vrp_pkg::STORE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] write_data
    input  logic [3:0] s_tuser,   // [0] kind, [3:1] reg_select
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] read_data
);

    localparam int unsigned IDX_W  = $clog2(STORE_DEPTH);
    localparam int unsigned ADDR_W = vrp_pkg::ADDR_W;

    logic                kind;
    logic [2:0]          reg_select;
    logic [7:0]          write_data;
    logic                accept;
    logic                advance;
    logic                store_busy;
    logic [7:0]          store_rdata;
    logic [IDX_W-1:0]    store_index;
    vrp_pkg::store_ctl_t store_ctl;

    logic [7:0]        ctrl1_reg, ctrl1_next;
    logic [7:0]        ctrl2_reg, ctrl2_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              low_next_reg, low_next_next;
    logic              dummy_reg, dummy_next;
    logic [ADDR_W-1:0] step;

    logic       mid_valid_reg;
    logic       mid_mem_reg, mid_mem_next;
    logic [7:0] mid_data_reg, mid_data_next;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;

    assign kind       = s_tuser[0];
    assign reg_select = s_tuser[3:1];
    assign write_data = s_tdata[7:0];

    // Handshake: the middle stage moves on whenever the output is free.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !store_busy && (!mid_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    assign step        = ctrl1_reg[2] ? vrp_pkg::STEP_WIDE : vrp_pkg::STEP_NARROW;
    assign store_index = IDX_W'(vrp_pkg::addr_mod(addr_reg, STORE_DEPTH));

    // Register decode and next state for the accepted item.
    always_comb begin
        ctrl1_next    = ctrl1_reg;
        ctrl2_next    = ctrl2_reg;
        addr_next     = addr_reg;
        low_next_next = low_next_reg;
        dummy_next    = dummy_reg;
        mid_mem_next  = 1'b0;
        mid_data_next = 8'h00;
        store_ctl     = '0;
        if (kind == vrp_pkg::KIND_WRITE) begin
            case (reg_select)
                vrp_pkg::SEL_CTRL1: begin
                    ctrl1_next    = write_data;
                    mid_data_next = write_data;
                end
                vrp_pkg::SEL_CTRL2: begin
                    ctrl2_next    = write_data;
                    mid_data_next = write_data;
                end
                vrp_pkg::SEL_ADDRESS: begin
                    dummy_next    = 1'b1;
                    mid_data_next = write_data;
                    if (low_next_reg) begin
                        addr_next     = {addr_reg[ADDR_W-1:8], write_data};
                        low_next_next = 1'b0;
                    end else begin
                        addr_next     = {write_data[5:0], addr_reg[7:0]};
                        low_next_next = 1'b1;
                    end
                end
                vrp_pkg::SEL_DATA: begin
                    store_ctl.wr = 1'b1;
                    addr_next    = addr_reg + step;
                end
                default: begin
                end
            endcase
        end else begin
            case (reg_select)
                vrp_pkg::SEL_CTRL1:  mid_data_next = ctrl1_reg;
                vrp_pkg::SEL_CTRL2:  mid_data_next = ctrl2_reg;
                vrp_pkg::SEL_STATUS: mid_data_next = vrp_pkg::STATUS_VALUE;
                vrp_pkg::SEL_DATA: begin
                    if (dummy_reg) begin
                        dummy_next = 1'b0;
                    end else begin
                        store_ctl.rd = 1'b1;
                        mid_mem_next = 1'b1;
                        addr_next    = addr_reg + step;
                    end
                end
                default: begin
                end
            endcase
        end
        // Strobes only fire for an accepted item.
        store_ctl.wr = store_ctl.wr && accept;
        store_ctl.rd = store_ctl.rd && accept;
    end

    // Port state, updated at the accept edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg    <= 8'h00;
            ctrl2_reg    <= 8'h00;
            addr_reg     <= '0;
            low_next_reg <= 1'b0;
            dummy_reg    <= 1'b0;
        end else if (accept) begin
            ctrl1_reg    <= ctrl1_next;
            ctrl2_reg    <= ctrl2_next;
            addr_reg     <= addr_next;
            low_next_reg <= low_next_next;
            dummy_reg    <= dummy_next;
        end
    end

    // Middle stage: waits for the store read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (accept) begin
            mid_valid_reg <= 1'b1;
        end else if (advance) begin
            mid_valid_reg <= 1'b0;
        end
        if (accept) begin
            mid_mem_reg  <= mid_mem_next;
            mid_data_reg <= mid_data_next;
        end
    end

    // Output register: picks the store byte or the decoded byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= mid_valid_reg;
        end
        if (advance && mid_valid_reg) begin
            out_data_reg <= mid_mem_reg ? store_rdata : mid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    vrp_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (store_ctl),
        .index   (store_index),
        .wdata   (write_data),
        .rdata   (store_rdata),
        .busy    (store_busy)
    );

endmodule

// ===== rtl/vrp_checker.sv =====
module vrp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Reset empties the output.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // The store clearing pass follows reset, so no item is taken just after it.
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("item accepted during store clearing");

    // Once an accepted item has passed the middle stage, the output holds an
    // item, either that one or an older one still waiting for the receiver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted item did not reach the output");

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

endmodule

bind video_ram_register_port_unit vrp_checker u_vrp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/video_ram_register_port_unit_tb.sv =====
module video_ram_register_port_unit_tb;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] write_data
    logic [3:0] s_tuser;    // [0] kind, [3:1] reg_select
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] read_data

    // Mirror of the port state, kept in step with every accepted item.
    logic [7:0]                ctrl_one_m;
    logic [7:0]                ctrl_two_m;
    logic [vrp_pkg::ADDR_W-1:0] vaddr_m;
    logic                      low_next_m;
    logic                      dummy_pend_m;
    logic [7:0]                vram_mirror [vrp_pkg::STORE_DEPTH_DEF];

    // Read bytes still owed by the block, oldest first.
    logic [7:0] owed_bytes [$];
    logic [7:0] head_byte;

    int bad_bytes = 0;
    int items_sent = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    video_ram_register_port_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a period of two units.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Works out the byte one access returns and updates the mirrored state.
    function automatic logic [7:0] access_byte(input logic kind, input logic [2:0] sel,
                                               input logic [7:0] wbyte);
        logic [7:0]                 rbyte;
        logic [vrp_pkg::ADDR_W-1:0] step;
        rbyte = 8'h00;
        step = ctrl_one_m[2] ? vrp_pkg::STEP_WIDE : vrp_pkg::STEP_NARROW;
        if (kind == vrp_pkg::KIND_WRITE) begin
            case (sel)
                vrp_pkg::SEL_CTRL1: begin
                    ctrl_one_m = wbyte;
                    rbyte = wbyte;
                end
                vrp_pkg::SEL_CTRL2: begin
                    ctrl_two_m = wbyte;
                    rbyte = wbyte;
                end
                vrp_pkg::SEL_ADDRESS: begin
                    dummy_pend_m = 1'b1;
                    if (low_next_m) begin
                        vaddr_m = {vaddr_m[vrp_pkg::ADDR_W-1:8], wbyte};
                        low_next_m = 1'b0;
                    end else begin
                        vaddr_m = {wbyte[5:0], vaddr_m[7:0]};
                        low_next_m = 1'b1;
                    end
                    rbyte = wbyte;
                end
                vrp_pkg::SEL_DATA: begin
                    vram_mirror[int'(vaddr_m) % vrp_pkg::STORE_DEPTH_DEF] = wbyte;
                    vaddr_m = vaddr_m + step;
                end
                default: rbyte = 8'h00;
            endcase
        end else begin
            case (sel)
                vrp_pkg::SEL_CTRL1:  rbyte = ctrl_one_m;
                vrp_pkg::SEL_CTRL2:  rbyte = ctrl_two_m;
                vrp_pkg::SEL_STATUS: rbyte = vrp_pkg::STATUS_VALUE;
                vrp_pkg::SEL_DATA: begin
                    // The first data read after an address write is a dummy.
                    if (dummy_pend_m) begin
                        dummy_pend_m = 1'b0;
                    end else begin
                        rbyte = vram_mirror[int'(vaddr_m) % vrp_pkg::STORE_DEPTH_DEF];
                        vaddr_m = vaddr_m + step;
                    end
                end
                default: rbyte = 8'h00;
            endcase
        end
        return rbyte;
    endfunction

    // Presents one item, waits for it to be taken and records the owed byte.
    task automatic send_access(input logic kind, input logic [2:0] sel,
                               input logic [7:0] wbyte);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, kind};
        s_tdata  <= wbyte;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        owed_bytes.push_back(access_byte(kind, sel, wbyte));
        items_sent++;
    endtask

    // Holds the sender off until every owed byte has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_bytes.size() != 0) @(posedge aclk);
    endtask

    // Loads a full 14-bit address, first completing a half-written one.
    task automatic load_address(input logic [vrp_pkg::ADDR_W-1:0] addr);
        if (low_next_m) begin
            send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_ADDRESS, 8'($urandom));
        end
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_ADDRESS,
                    {2'($urandom), addr[vrp_pkg::ADDR_W-1:8]});
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_ADDRESS, addr[7:0]);
    endtask

    // Readback of the control registers, the fixed status and unused selects.
    task automatic test_register_readback();
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_CTRL1, 8'hFF);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_CTRL1, 8'h00);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_CTRL2, 8'hA5);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_CTRL2, 8'hFF);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_STATUS, 8'h3C);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_STATUS, 8'h00);
        send_access(vrp_pkg::KIND_WRITE, 3'd7, 8'hFF);
        send_access(vrp_pkg::KIND_READ,  3'd5, 8'h00);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_CTRL1, 8'h00);
    endtask

    // Address toggle, wrap at the top, dummy reads and both strides.
    task automatic test_address_and_data();
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_ADDRESS, 8'hFF);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_ADDRESS, 8'hFF);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_DATA, 8'h81);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_ADDRESS, 8'h00);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        load_address(14'h3FFF);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_CTRL1, 8'h04);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_DATA, 8'h7E);
        send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_DATA, 8'hFF);
        load_address(14'h0000);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
        send_access(vrp_pkg::KIND_READ,  vrp_pkg::SEL_DATA, 8'h00);
    endtask

    // Mostly write-then-readback bursts, with control traffic and noise mixed in.
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int quota, input bit pause_midway);
        int stop_at;
        int nbytes;
        int pick;
        logic [vrp_pkg::ADDR_W-1:0] base;
        stop_at = items_sent + quota;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (items_sent < stop_at) begin
            if (pause_midway && items_sent >= stop_at - quota / 2) begin
                wait_for_drain();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(9);
            if (pick <= 5) begin
                case ($urandom_range(2))
                    0: base = {6'h00, 8'($urandom)};
                    1: base = 14'h3FC0 | 14'($urandom_range(63));
                    default: base = 14'($urandom);
                endcase
                if ($urandom_range(3) == 0) begin
                    send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_CTRL1, 8'($urandom));
                end
                nbytes = $urandom_range(1, 8);
                load_address(base);
                repeat (nbytes) begin
                    send_access(vrp_pkg::KIND_WRITE, vrp_pkg::SEL_DATA, 8'($urandom));
                end
                load_address(base);
                send_access(vrp_pkg::KIND_READ, vrp_pkg::SEL_DATA, 8'($urandom));
                repeat (nbytes) begin
                    send_access(vrp_pkg::KIND_READ, vrp_pkg::SEL_DATA, 8'($urandom));
                end
            end else if (pick == 6) begin
                send_access(vrp_pkg::KIND_WRITE, 3'($urandom_range(1)), 8'($urandom));
                send_access(vrp_pkg::KIND_READ, 3'($urandom_range(1)), 8'($urandom));
            end else begin
                send_access(1'($urandom), 3'($urandom_range(7)), 8'($urandom));
            end
        end
    endtask

    // Receiver: checks each result against the oldest owed byte and stalls at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_bytes.size() == 0) begin
                if (bad_bytes < 10) begin
                    $display("unexpected result: got %h with nothing owed", m_tdata);
                end
                bad_bytes++;
            end else begin
                head_byte = owed_bytes.pop_front();
                if (m_tdata !== head_byte) begin
                    if (bad_bytes < 10) begin
                        $display("read_data mismatch: expected %h, got %h",
                                 head_byte, m_tdata);
                    end
                    bad_bytes++;
                end
            end
        end
        m_tready <= !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);
    end

    // Hard stop well beyond the slowest correct run, clearing pass included.
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int spins;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 4'h0;
        m_tready <= 1'b1;
        ctrl_one_m   = 8'h00;
        ctrl_two_m   = 8'h00;
        vaddr_m      = '0;
        low_next_m   = 1'b0;
        dummy_pend_m = 1'b0;
        for (int i = 0; i < vrp_pkg::STORE_DEPTH_DEF; i++) vram_mirror[i] = 8'h00;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_readback();
        test_address_and_data();
        test_random_phase(0, 0, 125, 1'b0);
        test_random_phase(55, 0, 125, 1'b1);
        test_random_phase(0, 55, 125, 1'b0);
        test_random_phase(17, 17, 125, 1'b0);

        // Let the last items come back, then wait on for stray results.
        s_tvalid <= 1'b0;
        spins = 0;
        while (owed_bytes.size() != 0 && spins < 20000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (8) @(posedge aclk);
        if (bad_bytes == 0 && owed_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== video_ram_register_port_unit.f =====
rtl/vrp_pkg.sv
rtl/vrp_store.sv
rtl/video_ram_register_port_unit.sv
rtl/vrp_checker.sv
dv/video_ram_register_port_unit_tb.sv
